// ----- hw/rtl/rcls_pkg.sv -----
package rcls_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int CFG_ADDR_W       = 6;

    // register indexes on the configuration port
    localparam logic [2:0] REG_OWN_HI    = 3'd0;
    localparam logic [2:0] REG_OWN_LO    = 3'd1;
    localparam logic [2:0] REG_TGT_HI    = 3'd2;
    localparam logic [2:0] REG_TGT_LO    = 3'd3;
    localparam logic [2:0] REG_IDENT_SEQ = 3'd4;
    localparam logic [2:0] REG_PROBE_CK  = 3'd5;

    localparam logic [1:0] CLASS_IGNORED = 2'd0;
    localparam logic [1:0] CLASS_UNREACH = 2'd1;
    localparam logic [1:0] CLASS_TIMEEXC = 2'd2;
    localparam logic [1:0] CLASS_ECHO    = 2'd3;

    localparam logic [7:0] ICMP_TYPE_UNREACH = 8'd1;
    localparam logic [7:0] ICMP_TYPE_TIMEEXC = 8'd3;
    localparam logic [7:0] ICMP_TYPE_ECHO    = 8'd129;

    // summary of one packet, handed from the parser to the classifier
    typedef struct packed {
        logic        overflow;
        logic        at_icmp;
        logic [3:0]  flags;
        logic [16:0] acc;
        logic        odd;
        logic [7:0]  hold;
        logic [15:0] rx_ck;
        logic [15:0] type_code;
        logic        ge56;
        logic        ge8;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
    } t_rec;

    // one's complement add with end-around carry
    function automatic logic [16:0] add_word(input logic [16:0] acc, input logic [15:0] w);
        logic [17:0] s;
        s = {1'b0, acc} + {2'b00, w};
        return {1'b0, s[15:0]} + {15'd0, s[17:16]};
    endfunction

endpackage

// ----- hw/rtl/rcls_front.sv -----
module rcls_front #(
    parameter int MAX_BYTES = rcls_pkg::MAX_PACKET_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_last_byte,
    input  logic [63:0]          i_own_hi,
    input  logic [63:0]          i_own_lo,
    input  logic [63:0]          i_tgt_hi,
    input  logic [63:0]          i_tgt_lo,
    input  logic [31:0]          i_ident_seq,
    input  logic [15:0]          i_probe_ck,
    output logic                 o_push,
    output rcls_pkg::t_rec       o_rec
);

    localparam int W = $clog2(MAX_BYTES + 1);

    typedef enum logic [2:0] {
        PH_HDR, PH_EXT_NH, PH_EXT_LEN, PH_EXT_SKIP, PH_ICMP, PH_DROP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [W-1:0] r_pos, n_pos, r_idx, n_idx;
    logic [10:0] r_rem, n_rem;
    logic [11:0] ext_n;
    logic [7:0]  r_nh, n_nh, r_hold, n_hold, b, qb;
    logic [15:0] r_ext, n_ext, r_plen, n_plen, r_tc, n_tc, r_rxck, n_rxck, ulen;
    logic [16:0] r_acc, n_acc;
    logic        r_odd, n_odd, r_ovf, n_ovf, disp;
    logic [63:0] r_shi, n_shi, r_slo, n_slo, own_sel;
    logic [3:0]  r_flags, n_flags;
    logic [31:0] p32, i32;

    // expected byte of the quoted probe at ICMP offset 8..55
    function automatic logic [7:0] quoted(input logic [5:0] i, input logic [63:0] oh,
                                          input logic [63:0] ol, input logic [63:0] th,
                                          input logic [63:0] tl, input logic [31:0] is,
                                          input logic [15:0] ck);
        logic [7:0] r;
        case (i[5:3])
            3'd1: begin
                case (i[2:0])
                    3'd0: r = 8'h60;
                    3'd5: r = 8'h08;
                    3'd6: r = 8'h3a;
                    3'd7: r = 8'h01;
                    default: r = 8'h00;
                endcase
            end
            3'd2: r = oh[8*(7-i[2:0]) +: 8];
            3'd3: r = ol[8*(7-i[2:0]) +: 8];
            3'd4: r = th[8*(7-i[2:0]) +: 8];
            3'd5: r = tl[8*(7-i[2:0]) +: 8];
            default: begin
                case (i[2:0])
                    3'd0: r = 8'd128;
                    3'd2: r = ck[15:8];
                    3'd3: r = ck[7:0];
                    3'd4, 3'd5, 3'd6, 3'd7: r = is[8*(3-i[1:0]) +: 8];
                    default: r = 8'h00;
                endcase
            end
        endcase
        return r;
    endfunction

    assign b       = i_rx_byte;
    assign p32     = 32'(r_pos);
    assign i32     = 32'(r_idx);
    assign own_sel = (p32 < 32) ? i_own_hi : i_own_lo;
    assign ext_n   = {1'b0, i_rx_byte, 3'b000} + 12'd8;
    assign qb      = quoted(r_idx[5:0], i_own_hi, i_own_lo, i_tgt_hi, i_tgt_lo,
                            i_ident_seq, i_probe_ck);

    // update parse state for one byte
    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_idx = r_idx; n_rem = r_rem;
        n_nh = r_nh; n_hold = r_hold; n_ext = r_ext; n_plen = r_plen;
        n_tc = r_tc; n_rxck = r_rxck; n_acc = r_acc; n_odd = r_odd;
        n_ovf = r_ovf; n_shi = r_shi; n_slo = r_slo; n_flags = r_flags;
        disp = 1'b0;
        ulen = r_plen - r_ext;
        if (i_valid) begin
            if (p32 >= MAX_BYTES) begin
                n_ovf = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
                unique case (r_phase)
                    PH_HDR: begin
                        if (p32 == 0 && b[7:4] != 4'd6) n_flags[0] = 1'b0;
                        if (p32 == 4) n_plen[15:8] = b;
                        if (p32 == 5) n_plen[7:0] = b;
                        if (p32 == 6) n_nh = b;
                        if (p32 >= 8 && p32 < 16) n_shi = {r_shi[55:0], b};
                        if (p32 >= 16 && p32 < 24) n_slo = {r_slo[55:0], b};
                        if (p32 >= 24 && p32 < 40 && b != own_sel[8*(7-r_pos[2:0]) +: 8])
                            n_flags[1] = 1'b0;
                        if (p32 >= 8) begin
                            if (r_odd) begin
                                n_acc = rcls_pkg::add_word(r_acc, {r_hold, b});
                                n_odd = 1'b0;
                            end else begin
                                n_hold = b;
                                n_odd  = 1'b1;
                            end
                        end
                        if (p32 == 39) disp = 1'b1;
                    end
                    PH_EXT_NH: begin
                        n_nh    = b;
                        n_phase = PH_EXT_LEN;
                    end
                    PH_EXT_LEN: begin
                        n_ext   = r_ext + 16'(ext_n);
                        n_rem   = 11'(ext_n - 12'd2);
                        n_phase = PH_EXT_SKIP;
                    end
                    PH_EXT_SKIP: begin
                        if (r_rem != '0) n_rem = r_rem - 1'b1;
                        if (n_rem == '0) disp = 1'b1;
                    end
                    PH_ICMP: begin
                        if (i32 == 0) n_tc[15:8] = b;
                        if (i32 == 1) n_tc[7:0] = b;
                        if (i32 == 2) n_rxck[15:8] = b;
                        if (i32 == 3) n_rxck[7:0] = b;
                        if (i32 < 32'(ulen)) begin
                            if (r_odd) begin
                                n_acc = rcls_pkg::add_word(r_acc,
                                    {r_hold, (i32 == 2 || i32 == 3) ? 8'h00 : b});
                                n_odd = 1'b0;
                            end else begin
                                n_hold = (i32 == 2 || i32 == 3) ? 8'h00 : b;
                                n_odd  = 1'b1;
                            end
                        end
                        if (i32 >= 4 && i32 < 8 && b != i_ident_seq[8*(3-r_idx[1:0]) +: 8])
                            n_flags[2] = 1'b0;
                        if (i32 >= 8 && i32 < 56 && b != qb) n_flags[3] = 1'b0;
                        if (i32 < MAX_BYTES) n_idx = r_idx + 1'b1;
                    end
                    default: ;
                endcase
                // pick the next header handler
                if (disp) begin
                    if (n_nh == 8'h3a) begin
                        n_phase = PH_ICMP;
                        n_acc   = rcls_pkg::add_word(n_acc, n_plen - n_ext);
                        n_acc   = rcls_pkg::add_word(n_acc, 16'd58);
                    end else if (n_nh == 8'h00 || n_nh == 8'h2b || n_nh == 8'h3c) begin
                        n_phase = PH_EXT_NH;
                    end else begin
                        n_phase = PH_DROP;
                    end
                end
            end
        end
    end

    // summary of the finished packet
    always_comb begin
        o_push            = i_valid & i_last_byte;
        o_rec.overflow    = n_ovf;
        o_rec.at_icmp     = (n_phase == PH_ICMP);
        o_rec.flags       = n_flags;
        o_rec.acc         = n_acc;
        o_rec.odd         = n_odd;
        o_rec.hold        = n_hold;
        o_rec.rx_ck       = n_rxck;
        o_rec.type_code   = n_tc;
        o_rec.ge56        = 32'(n_idx) >= 56;
        o_rec.ge8         = 32'(n_idx) >= 8;
        o_rec.src_hi      = n_shi;
        o_rec.src_lo      = n_slo;
    end

    // hold state; clear it after the last beat of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last_byte)) begin
            r_phase <= PH_HDR; r_pos <= '0; r_idx <= '0; r_rem <= '0; r_nh <= '0;
            r_hold <= '0; r_ext <= '0; r_plen <= '0; r_tc <= '0; r_rxck <= '0;
            r_acc <= '0; r_odd <= 1'b0; r_ovf <= 1'b0; r_shi <= '0; r_slo <= '0;
            r_flags <= '1;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_idx <= n_idx; r_rem <= n_rem;
            r_nh <= n_nh; r_hold <= n_hold; r_ext <= n_ext; r_plen <= n_plen;
            r_tc <= n_tc; r_rxck <= n_rxck; r_acc <= n_acc; r_odd <= n_odd;
            r_ovf <= n_ovf; r_shi <= n_shi; r_slo <= n_slo; r_flags <= n_flags;
        end
    end

endmodule

// ----- hw/rtl/rcls_fifo.sv -----
module rcls_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcls_pkg::t_rec i_rec,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output rcls_pkg::t_rec o_rec
);

    rcls_pkg::t_rec r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rec   = r_mem[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // store payload
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_rec;
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ----- hw/rtl/rcls_back.sv -----
module rcls_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  rcls_pkg::t_rec i_rec,
    input  logic [63:0]    i_tgt_hi,
    input  logic [63:0]    i_tgt_lo,
    input  logic           i_pop,
    output logic           o_take,
    output logic           o_empty,
    output logic [1:0]     o_reply_class,
    output logic [63:0]    o_responder_hi,
    output logic [63:0]    o_responder_lo
);

    logic        r_valid;
    logic [1:0]  r_cls, cls;
    logic [63:0] r_hi, r_lo;
    logic [17:0] s1;
    logic [16:0] f1, f2;
    logic [15:0] computed;
    logic [7:0]  t, c;
    logic        quoted, echo;

    // fold the sum and classify
    always_comb begin
        t  = i_rec.type_code[15:8];
        c  = i_rec.type_code[7:0];
        s1 = {1'b0, i_rec.acc} + (i_rec.odd ? {2'b00, i_rec.hold, 8'h00} : 18'd0);
        f1 = {1'b0, s1[15:0]} + {15'd0, s1[17:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        computed = ~f2[15:0];
        quoted = i_rec.ge56 & i_rec.flags[3];
        echo   = i_rec.ge8 & i_rec.flags[2];
        cls = rcls_pkg::CLASS_IGNORED;
        if (!i_rec.overflow && i_rec.at_icmp && i_rec.flags[1:0] == 2'b11
            && computed == i_rec.rx_ck) begin
            if (t == rcls_pkg::ICMP_TYPE_UNREACH && quoted)
                cls = rcls_pkg::CLASS_UNREACH;
            else if (t == rcls_pkg::ICMP_TYPE_TIMEEXC && c == 8'd0 && quoted)
                cls = rcls_pkg::CLASS_TIMEEXC;
            else if (t == rcls_pkg::ICMP_TYPE_ECHO && c == 8'd0 && echo
                     && i_rec.src_hi == i_tgt_hi && i_rec.src_lo == i_tgt_lo)
                cls = rcls_pkg::CLASS_ECHO;
        end
    end

    assign o_take         = i_avail & (~r_valid | i_pop);
    assign o_empty        = ~r_valid;
    assign o_reply_class  = r_cls;
    assign o_responder_hi = r_hi;
    assign o_responder_lo = r_lo;

    // output register: load when empty or when the held beat leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cls <= cls;
            r_hi  <= (cls != rcls_pkg::CLASS_IGNORED) ? i_rec.src_hi : 64'd0;
            r_lo  <= (cls != rcls_pkg::CLASS_IGNORED) ? i_rec.src_lo : 64'd0;
        end
    end

endmodule

// ----- hw/rtl/icmpv6_reply_classifier_unit.sv -----
// ICMPv6 reply classifier for a traceroute probe.
// Input queue side: one packet byte per beat on i_rx_byte, i_last_byte marking
// the final byte; a beat is taken when push is high and full is low.
// Result queue side: one result per packet (class and source address),
// shown while empty is low and taken when pop is high.
// Configuration: APB-style port, 64-bit registers at 8-byte steps
// (own address hi/lo, target hi/lo, probe identifier/sequence, probe checksum).
// Throughput: one byte per cycle while full is low. The parser updates counters,
// compares and the checksum sum as each byte is taken.
// After its last byte is taken, a result is registered in the summary queue,
// then classified into the output register once that register is free or popped.
// A two-entry summary queue sits between parser and classifier, so the
// parser keeps taking bytes while a result waits; full rises only when both
// entries and the output register are occupied by unread results.
// Reset clears configuration to zero, parser state and both queues.
module icmpv6_reply_classifier_unit #(
    parameter int MAX_PACKET_BYTES = rcls_pkg::MAX_PACKET_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_last_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      o_reply_class,
    output logic [63:0]                     o_responder_hi,
    output logic [63:0]                     o_responder_lo,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcls_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);

    logic [63:0]    r_own_hi, r_own_lo, r_tgt_hi, r_tgt_lo;
    logic [31:0]    r_ident_seq;
    logic [15:0]    r_probe_ck;
    logic [2:0]     reg_idx;
    logic           fe_push, q_full, q_empty, bk_take;
    rcls_pkg::t_rec fe_rec, q_rec;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign full    = q_full;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_hi <= '0; r_own_lo <= '0; r_tgt_hi <= '0; r_tgt_lo <= '0;
            r_ident_seq <= '0; r_probe_ck <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                rcls_pkg::REG_OWN_HI:    r_own_hi    <= pwdata;
                rcls_pkg::REG_OWN_LO:    r_own_lo    <= pwdata;
                rcls_pkg::REG_TGT_HI:    r_tgt_hi    <= pwdata;
                rcls_pkg::REG_TGT_LO:    r_tgt_lo    <= pwdata;
                rcls_pkg::REG_IDENT_SEQ: r_ident_seq <= pwdata[31:0];
                rcls_pkg::REG_PROBE_CK:  r_probe_ck  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // configuration reads
    always_comb begin
        unique case (reg_idx)
            rcls_pkg::REG_OWN_HI:    prdata = r_own_hi;
            rcls_pkg::REG_OWN_LO:    prdata = r_own_lo;
            rcls_pkg::REG_TGT_HI:    prdata = r_tgt_hi;
            rcls_pkg::REG_TGT_LO:    prdata = r_tgt_lo;
            rcls_pkg::REG_IDENT_SEQ: prdata = {32'd0, r_ident_seq};
            rcls_pkg::REG_PROBE_CK:  prdata = {48'd0, r_probe_ck};
            default:                 prdata = 64'd0;
        endcase
    end

    rcls_front #(.MAX_BYTES(MAX_PACKET_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(push & ~q_full),
        .i_rx_byte(i_rx_byte), .i_last_byte(i_last_byte),
        .i_own_hi(r_own_hi), .i_own_lo(r_own_lo), .i_tgt_hi(r_tgt_hi),
        .i_tgt_lo(r_tgt_lo), .i_ident_seq(r_ident_seq), .i_probe_ck(r_probe_ck),
        .o_push(fe_push), .o_rec(fe_rec)
    );

    rcls_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fe_push), .i_rec(fe_rec),
        .i_pop(bk_take), .o_full(q_full), .o_empty(q_empty), .o_rec(q_rec)
    );

    rcls_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(~q_empty), .i_rec(q_rec),
        .i_tgt_hi(r_tgt_hi), .i_tgt_lo(r_tgt_lo), .i_pop(pop), .o_take(bk_take),
        .o_empty(empty), .o_reply_class(o_reply_class),
        .o_responder_hi(o_responder_hi), .o_responder_lo(o_responder_lo)
    );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BYTES   = 1300;

    typedef enum int {PH_HDR, PH_EXT_NH, PH_EXT_LEN, PH_EXT_SKIP, PH_ICMP, PH_DROP} t_parse;

    typedef struct {
        logic [1:0]  cls;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_reply;

    typedef struct {
        logic [7:0] rx;
        logic       last;
        logic [1:0] cls;
    } t_table_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_reply_class;
    logic [63:0] o_responder_hi;
    logic [63:0] o_responder_lo;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [rcls_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    icmpv6_reply_classifier_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_rx_byte(i_rx_byte), .i_last_byte(i_last_byte), .empty(empty), .pop(pop),
        .o_reply_class(o_reply_class), .o_responder_hi(o_responder_hi),
        .o_responder_lo(o_responder_lo), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register shadow
    logic [63:0] own_hi, own_lo, tgt_hi, tgt_lo;
    logic [31:0] ident_seq;
    logic [15:0] probe_ck;

    // per-packet parser shadow
    t_parse      ph;
    int unsigned pos, ext_left, nxt_hdr, ext_total, pay_len, icmp_idx, csum;
    int unsigned hold_byte, rx_ck, tc_word, flags;
    bit          hold_valid, ovf;
    logic [63:0] src_hi, src_lo;

    t_reply replies_due[$];
    logic [7:0] pkt[$];
    int errors = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    bit want_hold = 0;

    function automatic void clear_packet();
        ph = PH_HDR;
        pos = 0; ext_left = 0; nxt_hdr = 0; ext_total = 0; pay_len = 0;
        icmp_idx = 0; csum = 0; hold_byte = 0; hold_valid = 0;
        src_hi = '0; src_lo = '0; tc_word = 0; flags = 4'hF; rx_ck = 0; ovf = 0;
    endfunction

    function automatic void fold_word(int unsigned w);
        csum += w & 16'hFFFF;
        csum = (csum & 16'hFFFF) + (csum >> 16);
    endfunction

    function automatic void sum_octet(int unsigned b);
        if (hold_valid) begin
            fold_word((hold_byte << 8) | b);
            hold_valid = 0;
        end else begin
            hold_byte = b;
            hold_valid = 1;
        end
    endfunction

    // bytes of our own probe as it comes back quoted
    function automatic logic [7:0] probe_octet(int unsigned k);
        logic [383:0] probe;
        probe = {8'h60, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h3a, 8'h01,
                 own_hi, own_lo, tgt_hi, tgt_lo, 8'd128, 8'd0, probe_ck, ident_seq};
        return probe[383 - 8 * k -: 8];
    endfunction

    function automatic void next_hdr_step();
        if (nxt_hdr == 'h3a) begin
            ph = PH_ICMP;
            fold_word((pay_len - ext_total) & 16'hFFFF);
            fold_word(58);
        end else if (nxt_hdr == 'h00 || nxt_hdr == 'h2b || nxt_hdr == 'h3c) begin
            ph = PH_EXT_NH;
        end else begin
            ph = PH_DROP;
        end
    endfunction

    function automatic void icmp_octet(int unsigned b);
        int unsigned ulen;
        ulen = (pay_len - ext_total) & 16'hFFFF;
        if (icmp_idx == 0) tc_word = b << 8;
        else if (icmp_idx == 1) tc_word |= b;
        else if (icmp_idx == 2) rx_ck = b << 8;
        else if (icmp_idx == 3) rx_ck |= b;
        if (icmp_idx < ulen) sum_octet((icmp_idx == 2 || icmp_idx == 3) ? 0 : b);
        if (icmp_idx >= 4 && icmp_idx < 8 && b != ident_seq[8 * (7 - icmp_idx) +: 8])
            flags &= ~4;
        if (icmp_idx >= 8 && icmp_idx < 56 && b != probe_octet(icmp_idx - 8))
            flags &= ~8;
        if (icmp_idx < rcls_pkg::MAX_PACKET_BYTES) icmp_idx++;
    endfunction

    function automatic void ip_hdr_octet(int unsigned p, int unsigned b);
        logic [63:0] want;
        if (p == 0 && (b >> 4) != 6) flags &= ~1;
        if (p == 4) pay_len = b << 8;
        if (p == 5) pay_len |= b;
        if (p == 6) nxt_hdr = b;
        if (p >= 8 && p < 16) src_hi = {src_hi[55:0], b[7:0]};
        if (p >= 16 && p < 24) src_lo = {src_lo[55:0], b[7:0]};
        if (p >= 24 && p < 40) begin
            want = (p < 32) ? own_hi : own_lo;
            if (b != want[8 * (7 - ((p - 24) % 8)) +: 8]) flags &= ~2;
        end
        if (p >= 8) sum_octet(b);
        if (p == 39) next_hdr_step();
    endfunction

    function automatic logic [1:0] classify_packet();
        int unsigned folded, computed, t, c;
        bit quoted, echo;
        t = tc_word >> 8;
        c = tc_word & 'hFF;
        if (ovf || ph != PH_ICMP || (flags & 3) != 3) return rcls_pkg::CLASS_IGNORED;
        folded = csum;
        if (hold_valid) begin
            folded += hold_byte << 8;
            folded = (folded & 16'hFFFF) + (folded >> 16);
        end
        folded = (folded & 16'hFFFF) + (folded >> 16);
        computed = ~folded & 16'hFFFF;
        if (computed != rx_ck) return rcls_pkg::CLASS_IGNORED;
        quoted = icmp_idx >= 56 && (flags & 8) != 0;
        echo = icmp_idx >= 8 && (flags & 4) != 0;
        if (t == rcls_pkg::ICMP_TYPE_UNREACH && quoted) return rcls_pkg::CLASS_UNREACH;
        if (t == rcls_pkg::ICMP_TYPE_TIMEEXC && c == 0 && quoted)
            return rcls_pkg::CLASS_TIMEEXC;
        if (t == rcls_pkg::ICMP_TYPE_ECHO && c == 0 && echo && src_hi == tgt_hi &&
            src_lo == tgt_lo)
            return rcls_pkg::CLASS_ECHO;
        return rcls_pkg::CLASS_IGNORED;
    endfunction

    // advance the shadow parser by one byte; returns 1 when a reply is due
    function automatic bit predict_reply(input logic [7:0] b, input bit last,
                                         output t_reply r);
        int unsigned n;
        if (pos >= rcls_pkg::MAX_PACKET_BYTES) begin
            ovf = 1;
        end else begin
            case (ph)
                PH_HDR: ip_hdr_octet(pos, b);
                PH_EXT_NH: begin
                    nxt_hdr = b;
                    ph = PH_EXT_LEN;
                end
                PH_EXT_LEN: begin
                    n = 8 + 8 * b;
                    ext_total = (ext_total + n) & 16'hFFFF;
                    ext_left = n - 2;
                    ph = PH_EXT_SKIP;
                end
                PH_EXT_SKIP: begin
                    if (ext_left > 0) ext_left--;
                    if (ext_left == 0) next_hdr_step();
                end
                PH_ICMP: icmp_octet(b);
                default: ;
            endcase
            pos++;
        end
        r = '{rcls_pkg::CLASS_IGNORED, '0, '0};
        if (!last) return 0;
        r.cls = classify_packet();
        if (r.cls != rcls_pkg::CLASS_IGNORED) begin
            r.hi = src_hi;
            r.lo = src_lo;
        end
        clear_packet();
        return 1;
    endfunction

    // offer one beat and hold it until the block takes it
    task automatic send_beat(input logic [7:0] b, input bit last, input bit use_row,
                             input logic [1:0] row_cls);
        t_reply r;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_rx_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (full);
        bytes_sent++;
        if (predict_reply(b, last, r)) begin
            if (use_row) r = '{row_cls, '0, '0};
            replies_due.push_back(r);
        end
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            rcls_pkg::REG_OWN_HI:    own_hi = val;
            rcls_pkg::REG_OWN_LO:    own_lo = val;
            rcls_pkg::REG_TGT_HI:    tgt_hi = val;
            rcls_pkg::REG_TGT_LO:    tgt_lo = val;
            rcls_pkg::REG_IDENT_SEQ: ident_seq = val[31:0];
            rcls_pkg::REG_PROBE_CK:  probe_ck = val[15:0];
            default: ;
        endcase
    endtask

    // drain, let the classifier settle, then load a new register set
    task automatic load_regs(input int mode);
        logic [63:0] v[6];
        push <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        foreach (v[k])
            v[k] = (mode == 0) ? 64'd0 : (mode == 1) ? '1 : {$urandom, $urandom};
        reg_write(rcls_pkg::REG_OWN_HI, v[0]);
        reg_write(rcls_pkg::REG_OWN_LO, v[1]);
        reg_write(rcls_pkg::REG_TGT_HI, v[2]);
        reg_write(rcls_pkg::REG_TGT_LO, v[3]);
        reg_write(rcls_pkg::REG_IDENT_SEQ, v[4]);
        reg_write(rcls_pkg::REG_PROBE_CK, v[5]);
    endtask

    function automatic logic [15:0] ones_sum(logic [7:0] data[$], int unsigned extra);
        int unsigned s;
        s = extra;
        for (int k = 0; k < data.size(); k += 2) begin
            s += {data[k], (k + 1 < data.size()) ? data[k + 1] : 8'h00};
            s = (s & 16'hFFFF) + (s >> 16);
        end
        return ~s[15:0];
    endfunction

    // build a reply packet with random content; pad extends echo data
    task automatic build_packet(input int pad);
        logic [7:0] icmp[$], pseudo[$], ext[$];
        logic [63:0] s_hi, s_lo, d_hi, d_lo;
        logic [15:0] ck, plen;
        logic [7:0] first_nh, nh_code;
        int kind, n_ext, len8;
        kind = (pad > 0) ? 2 : $urandom_range(0, 3);
        n_ext = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        s_hi = {$urandom, $urandom};
        s_lo = {$urandom, $urandom};
        if (kind == 2 && $urandom_range(0, 7) != 0) begin
            s_hi = tgt_hi;
            s_lo = tgt_lo;
        end
        d_hi = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : own_hi;
        d_lo = own_lo;
        case (kind)
            0: icmp = '{rcls_pkg::ICMP_TYPE_UNREACH, 8'($urandom)};
            1: icmp = '{rcls_pkg::ICMP_TYPE_TIMEEXC,
                        ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0};
            2: icmp = '{rcls_pkg::ICMP_TYPE_ECHO,
                        ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0};
            default: icmp = '{8'($urandom), 8'($urandom)};
        endcase
        icmp.push_back(8'h00);
        icmp.push_back(8'h00);
        if (kind == 2) begin
            for (int k = 3; k >= 0; k--) icmp.push_back(ident_seq[8 * k +: 8]);
            repeat ($urandom_range(0, 6) + pad) icmp.push_back(8'($urandom));
        end else if (kind < 2) begin
            repeat (4) icmp.push_back(8'($urandom));
            for (int k = 0; k < 48; k++) icmp.push_back(probe_octet(k));
            repeat ($urandom_range(0, 4)) icmp.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(2, 10)) icmp.push_back(8'($urandom));
        end
        first_nh = 8'h3a;
        for (int e = 0; e < n_ext; e++) begin
            nh_code = (e == 0) ? 8'h3a : first_nh;
            first_nh = ($urandom_range(0, 2) == 0) ? 8'h00 :
                       ($urandom_range(0, 1) == 0) ? 8'h2b : 8'h3c;
            len8 = $urandom_range(0, 1);
            ext.push_front(8'(len8));
            ext.push_front(nh_code);
            for (int k = 0; k < 6 + 8 * len8; k++) ext.insert(2, 8'($urandom));
        end
        pseudo = {};
        for (int k = 7; k >= 0; k--) pseudo.push_back(s_hi[8 * k +: 8]);
        for (int k = 7; k >= 0; k--) pseudo.push_back(s_lo[8 * k +: 8]);
        for (int k = 7; k >= 0; k--) pseudo.push_back(d_hi[8 * k +: 8]);
        for (int k = 7; k >= 0; k--) pseudo.push_back(d_lo[8 * k +: 8]);
        ck = ones_sum({pseudo, icmp}, icmp.size() + 58);
        if ($urandom_range(0, 15) == 0) ck = 16'($urandom);
        icmp[2] = ck[15:8];
        icmp[3] = ck[7:0];
        plen = ext.size() + icmp.size();
        if ($urandom_range(0, 15) == 0) plen = 16'($urandom);
        if ($urandom_range(0, 19) == 0) first_nh = 8'($urandom);
        pkt = {8'h60 | 8'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
               8'($urandom), plen[15:8], plen[7:0], first_nh, 8'($urandom)};
        if ($urandom_range(0, 29) == 0) pkt[0] = 8'($urandom);
        pkt = {pkt, pseudo, ext, icmp};
        // break some of the packets on the way
        case ($urandom_range(0, 11))
            0: pkt[$urandom_range(0, pkt.size() - 1)] ^= 8'($urandom_range(1, 255));
            1: pkt = pkt[0 : $urandom_range(0, pkt.size() - 1)];
            default: ;
        endcase
    endtask

    task automatic send_packet();
        foreach (pkt[k])
            send_beat(pkt[k], k == pkt.size() - 1, 0, rcls_pkg::CLASS_IGNORED);
    endtask

    t_table_row stim_rows[] = '{
        '{8'h00, 1'b1, rcls_pkg::CLASS_IGNORED}, '{8'hFF, 1'b1, rcls_pkg::CLASS_IGNORED},
        '{8'h60, 1'b1, rcls_pkg::CLASS_IGNORED}, '{8'h60, 1'b0, rcls_pkg::CLASS_IGNORED},
        '{8'h00, 1'b0, rcls_pkg::CLASS_IGNORED}, '{8'h00, 1'b0, rcls_pkg::CLASS_IGNORED},
        '{8'h00, 1'b0, rcls_pkg::CLASS_IGNORED}, '{8'h00, 1'b0, rcls_pkg::CLASS_IGNORED},
        '{8'h08, 1'b0, rcls_pkg::CLASS_IGNORED}, '{8'h3a, 1'b0, rcls_pkg::CLASS_IGNORED},
        '{8'hFF, 1'b1, rcls_pkg::CLASS_IGNORED}, '{8'h55, 1'b0, rcls_pkg::CLASS_IGNORED},
        '{8'hAA, 1'b1, rcls_pkg::CLASS_IGNORED}
    };

    // pop side: check each beat, stall on a changing pattern
    initial begin
        int stall_mode, mode_left, hold_left;
        t_reply want;
        stall_mode = 0; mode_left = 0; hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: expected no reply, got class %0d", $time, o_reply_class);
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_reply_class !== want.cls || o_responder_hi !== want.hi ||
                        o_responder_lo !== want.lo) begin
                        $display("%0t: expected class %0d src %h_%h, got class %0d src %h_%h",
                                 $time, want.cls, want.hi, want.lo, o_reply_class,
                                 o_responder_hi, o_responder_lo);
                        errors++;
                    end
                end
            end
            if (want_hold) begin
                hold_left = 400;
                want_hold = 0;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (stall_mode)
                    0: pop <= 1'b1;
                    1: pop <= $urandom_range(0, 1);
                    2: pop <= ($urandom_range(0, 9) == 0);
                    default: pop <= (mode_left % 4 != 0);
                endcase
            end
        end
    end

    // stop the run if no beat or register access moves for too long
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || psel) idle = 0;
            else idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int phase_target;
        own_hi = '0; own_lo = '0; tgt_hi = '0; tgt_lo = '0; ident_seq = '0; probe_ck = '0;
        clear_packet();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: runt packets and a header cut short
        foreach (stim_rows[k])
            send_beat(stim_rows[k].rx, stim_rows[k].last, 1, stim_rows[k].cls);

        // random phases, each under its own register set
        bytes_sent = 0;
        for (int phase = 0; bytes_sent < RANDOM_BYTES || phase < 6; phase++) begin
            load_regs(phase < 2 ? phase : 2);
            if (phase == 2) want_hold = 1;
            phase_target = bytes_sent + 220;
            while (bytes_sent < phase_target) begin
                if ($urandom_range(0, 2) == 0) begin
                    pkt = {};
                    repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
                end else begin
                    build_packet(0);
                end
                send_packet();
            end
        end
        push <= 1'b0;

        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/rcls_pkg.sv
hw/rtl/rcls_front.sv
hw/rtl/rcls_fifo.sv
hw/rtl/rcls_back.sv
hw/rtl/icmpv6_reply_classifier_unit.sv
dv/testbench.sv
